// ===== rtl/core/armdec_pkg.sv =====
// armdec_pkg: shared types and constants for the arm32 instruction decoder
// class, end kind and control-word codes plus the decoded record type
// no dependencies
`default_nettype none

package armdec_pkg;

	typedef enum logic [3:0] {
		CLS_DATAPROC = 4'd0,
		CLS_MUL      = 4'd1,
		CLS_MUL_LONG = 4'd2,
		CLS_SWAP     = 4'd3,
		CLS_HALF     = 4'd4,
		CLS_WORD     = 4'd5,
		CLS_BLOCK    = 4'd6,
		CLS_BRANCH   = 4'd7,
		CLS_SWI      = 4'd8,
		CLS_UNDEF    = 4'd9
	} insn_class_t;

	typedef enum logic [1:0] {
		END_CONTINUE = 2'd0,
		END_COND     = 2'd1,
		END_INDIRECT = 2'd2,
		END_DIRECT   = 2'd3
	} end_kind_t;

	// control word bit positions
	localparam int CB_SET_CC    = 0;
	localparam int CB_LOGIC_CC  = 1;
	localparam int CB_IMM       = 2;
	localparam int CB_SHIFT_REG = 3;
	localparam int CB_LOAD      = 4;
	localparam int CB_PRE       = 5;
	localparam int CB_UP        = 6;
	localparam int CB_WB        = 7;
	localparam int CB_B22       = 8;
	localparam int CB_LINK      = 9;
	localparam int CB_ACC       = 10;
	localparam int CB_WRITES    = 11;

	localparam logic [3:0] COND_ALWAYS = 4'he;
	localparam logic [3:0] COND_NEVER  = 4'hf;
	localparam logic [3:0] REG_PC      = 4'hf;
	localparam logic [3:0] REG_LR      = 4'he;
	localparam logic [3:0] OP_MOV      = 4'hd;
	localparam logic [3:0] OP_MVN      = 4'hf;

	// opcodes whose carry comes from the shifter (and, eor, tst, teq, orr, mov, bic, mvn)
	localparam logic [15:0] LOGIC_OPS = 16'b1111_0011_0000_0011;

	typedef struct packed {
		insn_class_t cls;
		logic [3:0]  cond;
		logic [3:0]  sub_op;
		logic [3:0]  rd;
		logic [3:0]  rn;
		logic [3:0]  rm;
		logic [3:0]  rs;
		logic [1:0]  shift_kind;
		logic [4:0]  shift_count;
		logic [31:0] operand;
		logic [11:0] ctrl;
		end_kind_t   end_kind;
	} decode_t;

endpackage

`default_nettype wire

// ===== rtl/core/arm32_instruction_decoder.sv =====
// arm32_instruction_decoder: decodes one 32-bit arm instruction word per cycle
// input register, single-pass decode logic, result register
// depends on armdec_pkg
//
//   channel   handshake              payload
//   command   start / busy           insn_word, insn_addr
//   result    result_valid (strobe)  insn_class .. end_kind
//
// one transaction per cycle; busy is always low
// the word passes the input register, then is decoded into the result register
// the branch target adder is the longest path
// reset clears only the valid flags of both stages
// the receiver cannot stall; each result is shown for exactly one cycle
`default_nettype none

module arm32_instruction_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] insn_word,
	input  wire logic [31:0] insn_addr,
	output logic             result_valid,
	output logic [3:0]       insn_class,
	output logic [3:0]       cond_code,
	output logic [3:0]       sub_op,
	output logic [3:0]       dest_reg,
	output logic [3:0]       base_reg,
	output logic [3:0]       index_reg,
	output logic [3:0]       amount_reg,
	output logic [1:0]       shift_kind,
	output logic [4:0]       shift_count,
	output logic [31:0]      operand_value,
	output logic [11:0]      control_bits,
	output logic [1:0]       end_kind
);

	logic                  valid_s1;
	logic [31:0]           word_s1;
	logic [31:0]           addr_s1;
	logic                  valid_s2;
	armdec_pkg::decode_t   rec_s2;
	armdec_pkg::decode_t   dec;
	logic [3:0]            top;
	logic [3:0]            op;
	logic [4:0]            rot;
	logic [31:0]           rot_imm;
	logic [31:0]           br_off;
	logic                  pcw;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			word_s1 <= insn_word;
			addr_s1 <= insn_addr;
		end
		if (valid_s1) begin
			rec_s2 <= dec;
		end
	end

	assign top     = word_s1[27:24];
	assign op      = word_s1[24:21];
	assign rot     = {word_s1[11:8], 1'b0};
	// a left shift by 32 gives zero, so rotation by zero passes the byte through
	assign rot_imm = ({24'd0, word_s1[7:0]} >> rot) |
		({24'd0, word_s1[7:0]} << (6'd32 - {1'b0, rot}));
	assign br_off  = {{6{word_s1[23]}}, word_s1[23:0], 2'b00};

	always_comb begin
		dec             = '0;
		dec.cls         = armdec_pkg::CLS_UNDEF;
		dec.cond        = word_s1[31:28];
		dec.end_kind    = armdec_pkg::END_CONTINUE;
		pcw             = 1'b0;

		if (word_s1[31:28] == armdec_pkg::COND_NEVER) begin
			dec.cond = armdec_pkg::COND_ALWAYS;
		end else if (word_s1[27:26] == 2'b00 && (word_s1[25] || !(word_s1[7] && word_s1[4]))) begin
			dec.cls    = armdec_pkg::CLS_DATAPROC;
			dec.sub_op = op;
			dec.rd     = word_s1[15:12];
			if (op != armdec_pkg::OP_MVN && op != armdec_pkg::OP_MOV) begin
				dec.rn = word_s1[19:16];
			end
			dec.ctrl[armdec_pkg::CB_SET_CC]   = word_s1[20];
			dec.ctrl[armdec_pkg::CB_LOGIC_CC] = word_s1[20] && armdec_pkg::LOGIC_OPS[op];
			if (word_s1[25]) begin
				dec.operand                  = rot_imm;
				dec.ctrl[armdec_pkg::CB_IMM] = 1'b1;
			end else begin
				dec.rm         = word_s1[3:0];
				dec.shift_kind = word_s1[6:5];
				if (word_s1[4]) begin
					dec.ctrl[armdec_pkg::CB_SHIFT_REG] = 1'b1;
					dec.rs                             = word_s1[11:8];
				end else begin
					dec.shift_count = word_s1[11:7];
				end
			end
			// test and compare opcodes write no register
			if (op[3:2] != 2'b10) begin
				dec.ctrl[armdec_pkg::CB_WRITES] = 1'b1;
				pcw = (word_s1[15:12] == armdec_pkg::REG_PC);
			end
		end else if (top[3:1] == 3'b000) begin
			if (word_s1[6:5] == 2'b00 && !top[0]) begin
				dec.rd = word_s1[19:16];
				dec.rn = word_s1[15:12];
				dec.rs = word_s1[11:8];
				dec.rm = word_s1[3:0];
				dec.ctrl[armdec_pkg::CB_SET_CC]   = word_s1[20];
				dec.ctrl[armdec_pkg::CB_LOGIC_CC] = word_s1[20];
				dec.ctrl[armdec_pkg::CB_ACC]      = word_s1[21];
				dec.ctrl[armdec_pkg::CB_WRITES]   = 1'b1;
				if (word_s1[23]) begin
					dec.cls                      = armdec_pkg::CLS_MUL_LONG;
					dec.sub_op                   = {3'd0, word_s1[22]};
					dec.ctrl[armdec_pkg::CB_B22] = word_s1[22];
					pcw = (word_s1[19:16] == armdec_pkg::REG_PC) ||
						(word_s1[15:12] == armdec_pkg::REG_PC);
				end else begin
					dec.cls = armdec_pkg::CLS_MUL;
					pcw     = (word_s1[19:16] == armdec_pkg::REG_PC);
				end
			end else if (word_s1[6:5] == 2'b00) begin
				dec.cls                         = armdec_pkg::CLS_SWAP;
				dec.rn                          = word_s1[19:16];
				dec.rd                          = word_s1[15:12];
				dec.rm                          = word_s1[3:0];
				dec.ctrl[armdec_pkg::CB_B22]    = word_s1[22];
				dec.ctrl[armdec_pkg::CB_WRITES] = 1'b1;
				pcw = (word_s1[15:12] == armdec_pkg::REG_PC);
			end else begin
				dec.cls    = armdec_pkg::CLS_HALF;
				dec.sub_op = {2'd0, word_s1[6:5]};
				dec.rn     = word_s1[19:16];
				dec.rd     = word_s1[15:12];
				if (word_s1[22]) begin
					dec.ctrl[armdec_pkg::CB_IMM] = 1'b1;
					dec.operand                  = {24'd0, word_s1[11:8], word_s1[3:0]};
				end else begin
					dec.rm = word_s1[3:0];
				end
				dec.ctrl[armdec_pkg::CB_LOAD]   = word_s1[20];
				dec.ctrl[armdec_pkg::CB_WRITES] = word_s1[20];
				dec.ctrl[armdec_pkg::CB_PRE]    = word_s1[24];
				dec.ctrl[armdec_pkg::CB_UP]     = word_s1[23];
				dec.ctrl[armdec_pkg::CB_WB]     = word_s1[21];
				pcw = (word_s1[20] && word_s1[15:12] == armdec_pkg::REG_PC) ||
					(word_s1[21] && word_s1[19:16] == armdec_pkg::REG_PC);
			end
		end else if (top[3:2] == 2'b01) begin
			dec.cls = armdec_pkg::CLS_WORD;
			dec.rn  = word_s1[19:16];
			dec.rd  = word_s1[15:12];
			if (word_s1[25]) begin
				dec.rm          = word_s1[3:0];
				dec.shift_kind  = word_s1[6:5];
				dec.shift_count = word_s1[11:7];
			end else begin
				dec.ctrl[armdec_pkg::CB_IMM] = 1'b1;
				dec.operand                  = {20'd0, word_s1[11:0]};
			end
			dec.ctrl[armdec_pkg::CB_LOAD]   = word_s1[20];
			dec.ctrl[armdec_pkg::CB_WRITES] = word_s1[20];
			dec.ctrl[armdec_pkg::CB_PRE]    = word_s1[24];
			dec.ctrl[armdec_pkg::CB_UP]     = word_s1[23];
			dec.ctrl[armdec_pkg::CB_WB]     = word_s1[21];
			dec.ctrl[armdec_pkg::CB_B22]    = word_s1[22];
			pcw = (word_s1[20] && word_s1[15:12] == armdec_pkg::REG_PC) ||
				(word_s1[21] && word_s1[19:16] == armdec_pkg::REG_PC);
		end else if (top[3:1] == 3'b100 && !word_s1[22]) begin
			dec.cls     = armdec_pkg::CLS_BLOCK;
			dec.rn      = word_s1[19:16];
			dec.operand = {16'd0, word_s1[15:0]};
			dec.ctrl[armdec_pkg::CB_LOAD]   = word_s1[20];
			dec.ctrl[armdec_pkg::CB_WRITES] = word_s1[20];
			dec.ctrl[armdec_pkg::CB_PRE]    = word_s1[24];
			dec.ctrl[armdec_pkg::CB_UP]     = word_s1[23];
			dec.ctrl[armdec_pkg::CB_WB]     = word_s1[21];
			// load of the pc from the register list, or writeback to a pc base register
			pcw = (word_s1[20] && word_s1[15]) ||
				(word_s1[21] && word_s1[19:16] == armdec_pkg::REG_PC);
		end else if (top[3:1] == 3'b101) begin
			dec.cls     = armdec_pkg::CLS_BRANCH;
			dec.operand = addr_s1 + 32'd8 + br_off;
			if (word_s1[24]) begin
				dec.ctrl[armdec_pkg::CB_LINK]   = 1'b1;
				dec.ctrl[armdec_pkg::CB_WRITES] = 1'b1;
				dec.rd                          = armdec_pkg::REG_LR;
			end
		end else if (top == 4'hf) begin
			dec.cls     = armdec_pkg::CLS_SWI;
			dec.operand = addr_s1 + 32'd4;
		end

		if (dec.cls == armdec_pkg::CLS_UNDEF) begin
			dec.sub_op      = '0;
			dec.rd          = '0;
			dec.rn          = '0;
			dec.rm          = '0;
			dec.rs          = '0;
			dec.shift_kind  = '0;
			dec.shift_count = '0;
			dec.ctrl        = '0;
			dec.operand     = addr_s1;
		end

		if (dec.cls == armdec_pkg::CLS_BRANCH) begin
			dec.end_kind = armdec_pkg::END_DIRECT;
		end else if (pcw || dec.cls == armdec_pkg::CLS_SWI || dec.cls == armdec_pkg::CLS_UNDEF) begin
			dec.end_kind = armdec_pkg::END_INDIRECT;
		end else if (dec.cond != armdec_pkg::COND_ALWAYS) begin
			dec.end_kind = armdec_pkg::END_COND;
		end else begin
			dec.end_kind = armdec_pkg::END_CONTINUE;
		end
	end

	assign result_valid  = valid_s2;
	assign insn_class    = rec_s2.cls;
	assign cond_code     = rec_s2.cond;
	assign sub_op        = rec_s2.sub_op;
	assign dest_reg      = rec_s2.rd;
	assign base_reg      = rec_s2.rn;
	assign index_reg     = rec_s2.rm;
	assign amount_reg    = rec_s2.rs;
	assign shift_kind    = rec_s2.shift_kind;
	assign shift_count   = rec_s2.shift_count;
	assign operand_value = rec_s2.operand;
	assign control_bits  = rec_s2.ctrl;
	assign end_kind      = rec_s2.end_kind;

endmodule

`default_nettype wire
